@@ src/lzss_win_pkg.sv @@
`default_nettype none
package lzss_win_pkg;

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] CFG_SKIP_COUNT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_OUT_LENGTH = 2'd1;

  // token format
  localparam int POS_W     = 12;
  localparam int LEN_W     = 5;
  localparam int MATCH_MIN = 3;
  localparam int MAX_MATCH = 18;
  localparam logic [7:0] FLAG_FILL = 8'hFF;

  // input word
  typedef struct packed {
    logic [7:0] in_byte;
    logic       in_last;
  } in_word_t;

  // result word
  typedef struct packed {
    logic [7:0] out_byte;
    logic       last_of_item;
    logic       stream_done;
  } out_word_t;

  // window control from the sequencer
  typedef struct packed {
    logic wr_en;
    logic rd_en;
    logic clear;
  } win_ctrl_t;

endpackage
`default_nettype wire

@@ src/lzss_window_decompressor.sv @@
`default_nettype none
// channel   direction  handshake              word
// in_       input      in_valid / in_stall    in_byte, in_last
// out_      output     out_valid / out_stall  out_byte, last_of_item, stream_done
// cfg_      input      cfg_valid / cfg_ready  cfg_index, cfg_data
//
// a flag, first match or ignored byte passes S_END alone, a literal S_PUT then
// S_END, a match S_RD and S_PUT per copied byte (len 3..18) then S_END, with one
// window read and one write per copied byte through the single window port pair;
// in_stall is high while a word is in work; the result register lets the next
// word in while a result waits. reset and in_last clear the window through a
// fill count, so there is no clearing pass. cfg_ready is always high.
module lzss_window_decompressor
  import lzss_win_pkg::*;
#(
  parameter int WINDOW_SIZE = 4096
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire in_word_t             in_word,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output out_word_t                 out_word,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [31:0]          cfg_data
);

  localparam int AW = $clog2(WINDOW_SIZE);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_RD   = 2'd1;
  localparam logic [1:0] S_PUT  = 2'd2;
  localparam logic [1:0] S_END  = 2'd3;

  logic [1:0]       state_r,      state_nxt;
  logic [15:0]      flag_bits_r,  flag_bits_nxt;
  logic             phase_r,      phase_nxt;
  logic [7:0]       match_low_r,  match_low_nxt;
  logic [31:0]      count_r,      count_nxt;
  logic             finished_r,   finished_nxt;
  logic             last_r,       last_nxt;
  logic [7:0]       lit_r,        lit_nxt;
  logic             src_mem_r,    src_mem_nxt;
  logic [AW-1:0]    cpy_addr_r,   cpy_addr_nxt;
  logic [LEN_W-1:0] cpy_left_r,   cpy_left_nxt;
  logic             pend_valid_r, pend_valid_nxt;
  logic [7:0]       pend_byte_r,  pend_byte_nxt;
  logic             out_valid_r,  out_valid_nxt;
  out_word_t        out_word_r,   out_word_nxt;
  logic [31:0]      skip_r;
  logic [31:0]      olen_r;

  win_ctrl_t        win_ctrl;
  logic [7:0]       win_wr_data;
  logic [7:0]       win_rd_data;

  logic             in_take;
  logic             out_free;
  logic             emit;
  logic [31:0]      count_inc;
  logic [31:0]      limit;
  logic             hit_limit;
  logic [7:0]       byte_cur;
  logic [POS_W-1:0] match_pos;

  assign in_stall  = (state_r != S_IDLE);
  assign in_take   = in_valid && (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;
  assign out_free  = !out_valid_r || !out_stall;

  // byte counting against skip and limit
  assign emit      = (count_r >= skip_r);
  assign count_inc = count_r + 32'd1;
  assign limit     = skip_r + olen_r;
  assign hit_limit = (olen_r != 32'd0) && (count_inc == limit);
  assign byte_cur  = src_mem_r ? win_rd_data : lit_r;
  assign match_pos = {in_word.in_byte[7:4], match_low_r};

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      skip_r <= '0;
      olen_r <= '0;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_SKIP_COUNT: skip_r <= cfg_data;
        CFG_OUT_LENGTH: olen_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // decode sequencer
  always_comb begin
    state_nxt      = state_r;
    flag_bits_nxt  = flag_bits_r;
    phase_nxt      = phase_r;
    match_low_nxt  = match_low_r;
    count_nxt      = count_r;
    finished_nxt   = finished_r;
    last_nxt       = last_r;
    lit_nxt        = lit_r;
    src_mem_nxt    = src_mem_r;
    cpy_addr_nxt   = cpy_addr_r;
    cpy_left_nxt   = cpy_left_r;
    pend_valid_nxt = pend_valid_r;
    pend_byte_nxt  = pend_byte_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_word_nxt   = out_word_r;
    win_ctrl       = '0;
    win_wr_data    = byte_cur;

    case (state_r)
      S_IDLE: begin
        if (in_take) begin
          last_nxt  = in_word.in_last;
          state_nxt = S_END;
          if (!finished_r) begin
            if (phase_r) begin
              // second match byte: start the copy
              cpy_addr_nxt  = AW'(match_pos);
              cpy_left_nxt  = {1'b0, in_word.in_byte[3:0]} + LEN_W'(MATCH_MIN);
              src_mem_nxt   = 1'b1;
              flag_bits_nxt = flag_bits_r >> 1;
              phase_nxt     = 1'b0;
              state_nxt     = S_RD;
            end else if (!flag_bits_r[8]) begin
              flag_bits_nxt = {FLAG_FILL, in_word.in_byte};
            end else if (flag_bits_r[0]) begin
              lit_nxt       = in_word.in_byte;
              src_mem_nxt   = 1'b0;
              flag_bits_nxt = flag_bits_r >> 1;
              state_nxt     = S_PUT;
            end else begin
              match_low_nxt = in_word.in_byte;
              phase_nxt     = 1'b1;
            end
          end
        end
      end

      S_RD: begin
        win_ctrl.rd_en = 1'b1;
        state_nxt      = S_PUT;
      end

      S_PUT: begin
        // a new result pushes the held one out, so wait for the output register
        if (!(emit && pend_valid_r && !out_free)) begin
          if (emit) begin
            if (pend_valid_r) begin
              out_valid_nxt = 1'b1;
              out_word_nxt  = '{out_byte: pend_byte_r, last_of_item: 1'b0,
                                stream_done: 1'b0};
            end
            pend_valid_nxt = 1'b1;
            pend_byte_nxt  = byte_cur;
          end
          count_nxt = count_inc;
          if (hit_limit) begin
            finished_nxt = 1'b1;
            state_nxt    = S_END;
          end else begin
            win_ctrl.wr_en = 1'b1;
            if (src_mem_r && (cpy_left_r > LEN_W'(1))) begin
              cpy_left_nxt = cpy_left_r - 1'b1;
              cpy_addr_nxt = cpy_addr_r + 1'b1;
              state_nxt    = S_RD;
            end else begin
              state_nxt = S_END;
            end
          end
        end
      end

      S_END: begin
        // the held result is the last one of the word
        if (!(pend_valid_r && !out_free)) begin
          if (pend_valid_r) begin
            out_valid_nxt  = 1'b1;
            out_word_nxt   = '{out_byte: pend_byte_r, last_of_item: 1'b1,
                               stream_done: finished_r};
            pend_valid_nxt = 1'b0;
          end
          if (last_r) begin
            win_ctrl.clear = 1'b1;
            flag_bits_nxt  = '0;
            phase_nxt      = 1'b0;
            match_low_nxt  = '0;
            count_nxt      = '0;
            finished_nxt   = 1'b0;
          end
          state_nxt = S_IDLE;
        end
      end

      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      flag_bits_r  <= '0;
      phase_r      <= 1'b0;
      match_low_r  <= '0;
      count_r      <= '0;
      finished_r   <= 1'b0;
      last_r       <= 1'b0;
      src_mem_r    <= 1'b0;
      cpy_addr_r   <= '0;
      cpy_left_r   <= '0;
      pend_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      flag_bits_r  <= flag_bits_nxt;
      phase_r      <= phase_nxt;
      match_low_r  <= match_low_nxt;
      count_r      <= count_nxt;
      finished_r   <= finished_nxt;
      last_r       <= last_nxt;
      src_mem_r    <= src_mem_nxt;
      cpy_addr_r   <= cpy_addr_nxt;
      cpy_left_r   <= cpy_left_nxt;
      pend_valid_r <= pend_valid_nxt;
      out_valid_r  <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    lit_r       <= lit_nxt;
    pend_byte_r <= pend_byte_nxt;
    out_word_r  <= out_word_nxt;
  end

  // ring window
  lzss_win_ram #(
    .WINDOW_SIZE (WINDOW_SIZE)
  ) u_ram (
    .clk     (clk),
    .rst_n   (rst_n),
    .ctrl    (win_ctrl),
    .wr_data (win_wr_data),
    .rd_addr (cpy_addr_r),
    .rd_data (win_rd_data)
  );

endmodule
`default_nettype wire

@@ src/lzss_win_ram.sv @@
`default_nettype none
module lzss_win_ram
  import lzss_win_pkg::*;
#(
  parameter int WINDOW_SIZE = 4096
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire win_ctrl_t                      ctrl,
  input  wire logic [7:0]                     wr_data,
  input  wire logic [$clog2(WINDOW_SIZE)-1:0] rd_addr,
  output logic      [7:0]                     rd_data
);

  localparam int AW = $clog2(WINDOW_SIZE);
  localparam logic [AW-1:0] START_POS = AW'(WINDOW_SIZE - MAX_MATCH);
  localparam logic [AW:0]   FILL_FULL = (AW+1)'(WINDOW_SIZE);

  logic [7:0]    mem [WINDOW_SIZE];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] wp_nxt;
  logic [AW:0]   fill_r;
  logic [AW:0]   fill_nxt;
  logic [7:0]    rd_q_r;
  logic          hit_r;
  logic [AW-1:0] rd_ofs;

  // write pointer and count of entries written since the last clear
  always_comb begin
    wp_nxt   = wp_r;
    fill_nxt = fill_r;
    if (ctrl.clear) begin
      wp_nxt   = START_POS;
      fill_nxt = '0;
    end else if (ctrl.wr_en) begin
      wp_nxt = wp_r + 1'b1;
      if (fill_r != FILL_FULL) begin
        fill_nxt = fill_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r   <= START_POS;
      fill_r <= '0;
    end else begin
      wp_r   <= wp_nxt;
      fill_r <= fill_nxt;
    end
  end

  // entries written so far form one run starting at the start position
  assign rd_ofs = rd_addr - START_POS;

  // window storage, one write and one registered read port
  always_ff @(posedge clk) begin
    if (ctrl.wr_en) begin
      mem[wp_r] <= wr_data;
    end
    if (ctrl.rd_en) begin
      rd_q_r <= mem[rd_addr];
      hit_r  <= ({1'b0, rd_ofs} < fill_r);
    end
  end

  // unwritten entries read as zero
  assign rd_data = hit_r ? rd_q_r : 8'h00;

endmodule
`default_nettype wire

@@ test/testbench.sv @@
`default_nettype none
module testbench;
  import lzss_win_pkg::*;

  localparam int WIN_SIZE = 4096;
  localparam logic [11:0] START_POS = 12'd4078;
  localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;
  // longest word is a match of 18 bytes, each read from and written to the window
  localparam int DRAIN_CYCLES = 48;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam int PHASE_WORDS = 75;

  // decoder prediction and expected result words
  class lzss_scoreboard;
    logic [7:0]  hist [WIN_SIZE];
    logic [11:0] wr_pos;
    logic [15:0] flags;
    bit          await_second;
    logic [7:0]  pos_low;
    logic [31:0] decoded;
    bit          halted;
    logic [31:0] skip_cnt;
    logic [31:0] emit_len;
    out_word_t   pending[$];
    out_word_t   fresh[$];
    int          errors;
    int          checked;

    function new();
      skip_cnt = '0;
      emit_len = '0;
      errors = 0;
      checked = 0;
      clear_stream();
    endfunction

    function void clear_stream();
      foreach (hist[i]) hist[i] = 8'h00;
      wr_pos = START_POS;
      flags = '0;
      await_second = 1'b0;
      pos_low = '0;
      decoded = '0;
      halted = 1'b0;
    endfunction

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
      case (idx)
        CFG_SKIP_COUNT: skip_cnt = data;
        CFG_OUT_LENGTH: emit_len = data;
        default: ;
      endcase
    endfunction

    // one decoded byte: emitted past the skip count, decoding stops at the limit
    function void emit_decoded(logic [7:0] b);
      out_word_t r;
      if (halted) return;
      if (decoded >= skip_cnt) begin
        r.out_byte = b;
        r.last_of_item = 1'b0;
        r.stream_done = 1'b0;
        fresh.push_back(r);
      end
      decoded = decoded + 32'd1;
      if (emit_len != 32'd0 && decoded == skip_cnt + emit_len) begin
        halted = 1'b1;
        return;
      end
      hist[wr_pos] = b;
      wr_pos = wr_pos + 12'd1;
    endfunction

    // accepted input word: decode it and queue the result words it causes
    function void note_input(in_word_t w);
      bit          was_halted;
      logic [11:0] src;
      int          len;
      out_word_t   r;
      was_halted = halted;
      fresh.delete();
      if (!halted) begin
        if (await_second) begin
          src = {w.in_byte[7:4], pos_low};
          len = int'(w.in_byte[3:0]) + MATCH_MIN;
          // copy may overlap bytes written earlier in the same match
          for (int i = 0; i < len && !halted; i++)
            emit_decoded(hist[src + 12'(i)]);
          flags = flags >> 1;
          await_second = 1'b0;
        end else if (!flags[8]) begin
          flags = {FLAG_FILL, w.in_byte};
        end else if (flags[0]) begin
          emit_decoded(w.in_byte);
          flags = flags >> 1;
        end else begin
          pos_low = w.in_byte;
          await_second = 1'b1;
        end
      end
      if (fresh.size() > 0) begin
        r = fresh[fresh.size()-1];
        r.last_of_item = 1'b1;
        if (halted && !was_halted) r.stream_done = 1'b1;
        fresh[fresh.size()-1] = r;
      end
      foreach (fresh[i]) pending.push_back(fresh[i]);
      if (w.in_last) clear_stream();
    endfunction

    task report(string msg);
      errors++;
      if (errors <= 20) $display("mismatch at %0t: %s", $time, msg);
    endtask

    task check_result(out_word_t got);
      out_word_t want;
      if (pending.size() == 0) begin
        report($sformatf("result word %h with none expected", got));
        return;
      end
      want = pending.pop_front();
      checked++;
      if (got.out_byte !== want.out_byte)
        report($sformatf("out_byte %h, expected %h", got.out_byte, want.out_byte));
      if (got.last_of_item !== want.last_of_item)
        report($sformatf("last_of_item %b, expected %b (byte %h)",
                         got.last_of_item, want.last_of_item, want.out_byte));
      if (got.stream_done !== want.stream_done)
        report($sformatf("stream_done %b, expected %b (byte %h)",
                         got.stream_done, want.stream_done, want.out_byte));
    endtask
  endclass

  logic                 clk;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  in_word_t             in_word = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  out_word_t            out_word;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [31:0]          cfg_data = '0;

  lzss_scoreboard sb;
  int idle_pct = 0;
  int stall_pct = 0;
  int words_sent = 0;
  int streams = 0;
  int idle_cycles = 0;
  logic [7:0] stream_q[$];

  lzss_window_decompressor dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stall, check every accepted result word
  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < stall_pct);
    if (rst_n && out_valid && !out_stall) sb.check_result(out_word);
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("no handshake for %0d cycles, %0d result words outstanding",
               idle_cycles, sb.pending.size());
      $display("Some tests failed");
      $finish;
    end
  end

  // one input word, with random sender gaps; valid stays high for the next word
  task automatic send_word(logic [7:0] b, logic last);
    in_word_t w;
    w.in_byte = b;
    w.in_last = last;
    while ($urandom_range(99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word <= w;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    words_sent++;
  endtask

  task automatic send_queued();
    foreach (stream_q[i]) send_word(stream_q[i], i == stream_q.size() - 1);
    streams++;
  endtask

  // let the block finish any word in work before touching registers
  task automatic wait_idle();
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sb.set_reg(idx, data);
    @(posedge clk);
  endtask

  task automatic set_limits(logic [31:0] skip, logic [31:0] len);
    wait_idle();
    write_reg(CFG_SKIP_COUNT, skip);
    write_reg(CFG_OUT_LENGTH, len);
  endtask

  // well-formed stream: flag bytes, literals and matches mostly pointing back
  // into recent output; optionally cut short anywhere, even mid-token
  task automatic send_stream(int ntok, bit cut_short);
    logic [7:0]  flag;
    logic [11:0] mpos;
    int          done_tok;
    int          produced;
    int          back;
    int          len;
    int          keep;
    done_tok = 0;
    produced = 0;
    stream_q.delete();
    while (done_tok < ntok) begin
      flag = 8'($urandom);
      stream_q.push_back(flag);
      for (int k = 0; k < 8 && done_tok < ntok; k++) begin
        if (flag[k]) begin
          stream_q.push_back(8'($urandom));
          produced++;
        end else begin
          len = $urandom_range(MATCH_MIN, MAX_MATCH);
          if (produced > 0 && $urandom_range(3) != 0) begin
            back = $urandom_range(1, produced < 40 ? produced : 40);
            mpos = START_POS + 12'(produced - back);
          end else begin
            mpos = 12'($urandom);
          end
          stream_q.push_back(mpos[7:0]);
          stream_q.push_back({mpos[11:8], 4'(len - MATCH_MIN)});
          produced += len;
        end
        done_tok++;
      end
    end
    if (cut_short) begin
      keep = $urandom_range(1, stream_q.size());
      while (stream_q.size() > keep) void'(stream_q.pop_back());
    end
    send_queued();
  endtask

  initial begin
    int idle_tab[4];
    int stall_tab[4];
    logic [31:0] skip_tab[4];
    logic [31:0] len_tab[4];
    int phase_start;
    idle_tab = '{0, 61, 0, 23};
    stall_tab = '{0, 0, 61, 23};
    skip_tab = '{32'd0, 32'd7, 32'd0, 32'd11};
    len_tab = '{32'd0, 32'd0, 32'd30, 32'd13};
    sb = new();
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset registers: literal 00, longest match overlapping the start
    // position, literal ff, match reading position 0 past the wrap, final literal
    stream_q = '{8'hF5, 8'h00, 8'hEE, 8'hFF, 8'hFF, 8'h00, 8'h00, 8'h80};
    send_queued();

    // limit hit inside a match, then ignored words up to the stream end
    set_limits(32'd2, 32'd5);
    stream_q = '{8'h01, 8'h41, 8'hEE, 8'h05, 8'h12, 8'h34, 8'h56};
    send_queued();

    // skip plus length wraps: limit reached while still skipping, no result
    set_limits(32'hFFFF_FFFF, 32'd3);
    write_reg(CFG_UNUSED, 32'hFFFF_FFFF);
    stream_q = '{8'hFF, 8'h11, 8'h22, 8'h33};
    send_queued();

    // stream ending on the first match byte drops the partial token
    set_limits(32'd0, 32'hFFFF_FFFF);
    stream_q = '{8'h00, 8'h10};
    send_queued();
    stream_q = '{8'h02, 8'h7E, 8'hEE, 8'h0A, 8'hC3};
    send_queued();

    // random streams under each idle mix and register setting
    for (int ph = 0; ph < 4; ph++) begin
      set_limits(skip_tab[ph], len_tab[ph]);
      idle_pct = idle_tab[ph];
      stall_pct = stall_tab[ph];
      phase_start = words_sent;
      while (words_sent - phase_start < PHASE_WORDS) begin
        if ($urandom_range(9) == 0) begin
          // noise: arbitrary bytes closed by a stream end
          stream_q.delete();
          repeat ($urandom_range(1, 6)) stream_q.push_back(8'($urandom));
          send_queued();
        end else begin
          send_stream($urandom_range(2, 12), $urandom_range(7) == 0);
        end
      end
    end

    wait_idle();
    $display("sent %0d input words in %0d streams, checked %0d result words",
             words_sent, streams, sb.checked);
    $display("eight register settings, idle mixes none, sender, receiver and both");
    if (sb.errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("%0d mismatches", sb.errors);
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
`default_nettype wire

@@ lzss_window_decompressor.f @@
src/lzss_win_pkg.sv
src/lzss_win_ram.sv
src/lzss_window_decompressor.sv
test/testbench.sv
